### rtl/ffc_pkg.sv
// ----------------------------------------------------------------------------
// ffc_pkg
// Types and constants shared by the feedback frame checker modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ffc_pkg;

  localparam logic [7:0] HDR_BYTE = 8'h53;
  localparam logic [7:0] EOL_BYTE = 8'h0A;

  localparam logic [7:0] CMD_RESET     = 8'd70;
  localparam logic [7:0] PAY_LEN_RESET = 8'd56;

  localparam int unsigned POS_CMD     = 3;
  localparam int unsigned POS_LEN_LO  = 4;
  localparam int unsigned POS_LEN_HI  = 5;
  localparam int unsigned POS_PAYLOAD = 6;
  localparam int unsigned POS_CK_OFS  = 6;
  localparam int unsigned POS_END_OFS = 7;

  typedef enum logic [0:0] {
    REG_COMMAND     = 1'b0,
    REG_PAYLOAD_LEN = 1'b1
  } reg_index_t;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_BAD_HEADER   = 3'd1,
    ST_BAD_COMMAND  = 3'd2,
    ST_BAD_SIZE     = 3'd3,
    ST_BAD_END      = 3'd4,
    ST_BAD_CHECKSUM = 3'd5
  } status_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } in_item_t;

  typedef struct packed {
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic       frame_done;
    logic [2:0] frame_status;
  } out_item_t;

  typedef struct packed {
    logic [7:0] command;
    logic [7:0] payload_len;
  } cfg_t;

endpackage

`default_nettype wire

### rtl/ffc_cfg.sv
// ----------------------------------------------------------------------------
// ffc_cfg
// Configuration registers; payload length saturated to the supported maximum.
// ----------------------------------------------------------------------------
`default_nettype none

module ffc_cfg #(
  parameter int unsigned MAX_PAYLOAD_BYTES = 255
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_wr_en,
  input  wire logic [0:0]   cfg_index,
  input  wire logic [7:0]   cfg_wr_data,
  output ffc_pkg::cfg_t     cfg
);

  localparam logic [7:0] MaxLen = 8'(MAX_PAYLOAD_BYTES);

  logic [7:0] command;
  logic [7:0] payload_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      command     <= ffc_pkg::CMD_RESET;
      payload_len <= ffc_pkg::PAY_LEN_RESET;
    end else if (cfg_wr_en) begin
      unique case (ffc_pkg::reg_index_t'(cfg_index))
        ffc_pkg::REG_COMMAND:     command     <= cfg_wr_data;
        ffc_pkg::REG_PAYLOAD_LEN: payload_len <= cfg_wr_data;
      endcase
    end
  end

  always_comb begin
    cfg.command     = command;
    cfg.payload_len = (payload_len > MaxLen) ? MaxLen : payload_len;
  end

endmodule

`default_nettype wire

### rtl/ffc_parse.sv
// ----------------------------------------------------------------------------
// ffc_parse
// Frame position, running checksum and first-error tracking; one byte a step.
// ----------------------------------------------------------------------------
`default_nettype none

module ffc_parse #(
  parameter int unsigned POS_W = 9
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               step,
  input  wire ffc_pkg::in_item_t  item,
  input  wire ffc_pkg::cfg_t      cfg,
  output ffc_pkg::out_item_t      result
);

  logic [POS_W-1:0]    byte_position;
  logic [POS_W-1:0]    byte_position_next;
  logic [7:0]          running_sum;
  logic [7:0]          running_sum_next;
  ffc_pkg::status_t    sticky_error;
  ffc_pkg::status_t    sticky_error_next;

  logic [POS_W-1:0]    pos;
  logic [POS_W-1:0]    pos_inc;
  logic [POS_W-1:0]    pay_ofs;
  logic [POS_W-1:0]    ck_pos;
  logic [POS_W-1:0]    end_pos;
  logic [7:0]          b;

  always_comb begin
    b       = item.rx_byte;
    pos     = item.frame_start ? '0 : byte_position;
    pos_inc = pos + POS_W'(1);
    pay_ofs = pos - POS_W'(ffc_pkg::POS_PAYLOAD);
    ck_pos  = POS_W'(cfg.payload_len) + POS_W'(ffc_pkg::POS_CK_OFS);
    end_pos = POS_W'(cfg.payload_len) + POS_W'(ffc_pkg::POS_END_OFS);

    byte_position_next   = pos_inc;
    running_sum_next     = running_sum;
    sticky_error_next    = sticky_error;
    result               = '0;

    if (pos == '0) begin
      running_sum_next  = '0;
      sticky_error_next = (b != ffc_pkg::HDR_BYTE) ? ffc_pkg::ST_BAD_HEADER : ffc_pkg::ST_OK;
    end else if (pos >= end_pos) begin
      byte_position_next = '0;
      result.frame_done  = 1'b1;
      if (sticky_error != ffc_pkg::ST_OK) begin
        result.frame_status = sticky_error;
      end else if (b != ffc_pkg::EOL_BYTE) begin
        result.frame_status = ffc_pkg::ST_BAD_END;
      end else if (running_sum != '0) begin
        result.frame_status = ffc_pkg::ST_BAD_CHECKSUM;
      end else begin
        result.frame_status = ffc_pkg::ST_OK;
      end
    end else if (pos == ck_pos) begin
      running_sum_next = running_sum ^ b;
    end else begin
      running_sum_next = running_sum + b;
      if (pos == POS_W'(ffc_pkg::POS_CMD)) begin
        if (b != cfg.command && sticky_error == ffc_pkg::ST_OK) begin
          sticky_error_next = ffc_pkg::ST_BAD_COMMAND;
        end
      end else if (pos == POS_W'(ffc_pkg::POS_LEN_LO)) begin
        if (b != cfg.payload_len && sticky_error == ffc_pkg::ST_OK) begin
          sticky_error_next = ffc_pkg::ST_BAD_SIZE;
        end
      end else if (pos == POS_W'(ffc_pkg::POS_LEN_HI)) begin
        if (b != '0 && sticky_error == ffc_pkg::ST_OK) begin
          sticky_error_next = ffc_pkg::ST_BAD_SIZE;
        end
      end else if (pos >= POS_W'(ffc_pkg::POS_PAYLOAD)) begin
        result.payload_valid = 1'b1;
        result.payload_byte  = b;
        result.payload_index = 8'(pay_ofs);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      running_sum   <= '0;
      sticky_error  <= ffc_pkg::ST_OK;
    end else if (step) begin
      byte_position <= byte_position_next;
      running_sum   <= running_sum_next;
      sticky_error  <= sticky_error_next;
    end
  end

endmodule

`default_nettype wire

### rtl/feedback_frame_checker.sv
// ----------------------------------------------------------------------------
// feedback_frame_checker
// Checks received feedback frames byte by byte, passes payload bytes through
// and reports one status on the last byte of each frame.
//
//   channel   direction   handshake          payload
//   in        input       in_valid/in_stall   ffc_pkg::in_item_t
//   out       output      out_valid/out_stall ffc_pkg::out_item_t
//   cfg       input       cfg_wr_en           cfg_index, cfg_wr_data
//
// One item per cycle sustained while the output is not stalled; an accepted item
// reaches the output through the input register, then the result register.
// The byte counter, checksum adder and error register update once per item.
// Reset clears frame state and restores register defaults.
// An output stall holds the result register and, once the input register is
// full, stalls the input.
// ----------------------------------------------------------------------------
`default_nettype none

module feedback_frame_checker #(
  parameter int unsigned MAX_PAYLOAD_BYTES = 255
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output      logic                in_stall,
  input  wire ffc_pkg::in_item_t   in_item,
  output      logic                out_valid,
  input  wire logic                out_stall,
  output ffc_pkg::out_item_t       out_item,
  input  wire logic                cfg_wr_en,
  input  wire logic [0:0]          cfg_index,
  input  wire logic [7:0]          cfg_wr_data
);

  localparam int unsigned POS_W = $clog2(MAX_PAYLOAD_BYTES + 8);

  logic               hold_valid;
  ffc_pkg::in_item_t  hold_item;
  logic               advance;
  logic               step;
  ffc_pkg::cfg_t      cfg;
  ffc_pkg::out_item_t result;

  assign advance  = !out_valid || !out_stall;
  assign step     = hold_valid && advance;
  assign in_stall = hold_valid && !advance;

  ffc_cfg #(
    .MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES)
  ) u_cfg (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wr_data(cfg_wr_data),
    .cfg        (cfg)
  );

  ffc_parse #(
    .POS_W(POS_W)
  ) u_parse (
    .clk   (clk),
    .rst   (rst),
    .step  (step),
    .item  (hold_item),
    .cfg   (cfg),
    .result(result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!in_stall) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      hold_item <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= hold_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_item <= result;
    end
  end

endmodule

`default_nettype wire

### rtl/ffc_checker.sv
// ----------------------------------------------------------------------------
// ffc_checker
// Port-level checks for the feedback frame checker, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ffc_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire ffc_pkg::out_item_t out_item
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("output item changed while stalled");

  a_status_only_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.frame_done |-> out_item.frame_status == ffc_pkg::ST_OK)
    else $error("status set on a byte that does not end a frame");

  a_payload_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.payload_valid |->
      out_item.payload_byte == '0 && out_item.payload_index == '0)
    else $error("payload fields set on a non-payload byte");

  a_payload_not_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.payload_valid |-> !out_item.frame_done)
    else $error("payload byte flagged as end of frame");

endmodule

bind feedback_frame_checker ffc_checker u_ffc_checker (
  .clk      (clk),
  .rst      (rst),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_item (out_item)
);

`default_nettype wire
